@@ rtl/core/htfd_pkg.sv @@
// Shared types, constants and helpers of the header/tail frame deframer.
package htfd_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_W       = 32;
    localparam int PATTERN_BYTES   = PATTERN_W / BYTE_W;
    localparam int LEN_W           = 3;
    localparam int CNT_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam int DEF_MAX_HEADER_BYTES = 4;
    localparam int DEF_MAX_TAIL_BYTES   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_PATTERN  = 3'd0,
        CFG_HEADER_LEN      = 3'd1,
        CFG_TAIL_PATTERN    = 3'd2,
        CFG_TAIL_LEN        = 3'd3,
        CFG_VOLUME_CATEGORY = 3'd4,
        CFG_VOLUME_ONLY     = 3'd5,
        CFG_ACCEPT_ANY_TAIL = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_CATEGORY = 2'd1,
        PH_EVENT    = 2'd2,
        PH_TAIL     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] header_pattern;
        logic [LEN_W-1:0]     header_len;
        logic [PATTERN_W-1:0] tail_pattern;
        logic [LEN_W-1:0]     tail_len;
        logic [BYTE_W-1:0]    volume_category;
        logic                 volume_only;
        logic                 accept_any_tail;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] category_byte;
        logic [BYTE_W-1:0] event_byte;
        logic              is_volume;
    } result_t;

    // Byte idx of a packed pattern; positions past the register read as zero.
    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PATTERN_W-1:0] pat,
                                                       input logic [CNT_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        if (idx < CNT_W'(PATTERN_BYTES)) begin
            case (idx[1:0])
                2'd0: b = pat[7:0];
                2'd1: b = pat[15:8];
                2'd2: b = pat[23:16];
                2'd3: b = pat[31:24];
                default: b = '0;
            endcase
        end
        return b;
    endfunction

    // Clamp a configured length to the supported maximum.
    function automatic logic [CNT_W-1:0] used_len(input logic [LEN_W-1:0] len,
                                                  input logic [CNT_W-1:0] max_len);
        logic [CNT_W-1:0] l;
        l = {{(CNT_W-LEN_W){1'b0}}, len};
        return (l > max_len) ? max_len : l;
    endfunction

endpackage

@@ rtl/core/header_tail_frame_deframer_unit.sv @@
// Top level of the header/tail frame deframer.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_rx_byte
//   m_       out        m_valid / m_ready   m_category_byte, m_event_byte, m_is_volume
//   cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// One item per cycle unless the result stalls: each byte is registered, runs
// through the header/phase/tail update and lands in the result register. m_valid
// rises after a frame-ending byte passes the input and then the result register.
// Reset clears configuration, frame state and both valid flags.
// A stalled result holds the update of the next byte; the input register keeps it.
module header_tail_frame_deframer_unit #(
    parameter int MAX_HEADER_BYTES = htfd_pkg::DEF_MAX_HEADER_BYTES,
    parameter int MAX_TAIL_BYTES   = htfd_pkg::DEF_MAX_TAIL_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [htfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [htfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [htfd_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [htfd_pkg::BYTE_W-1:0]       m_category_byte,
    output logic [htfd_pkg::BYTE_W-1:0]       m_event_byte,
    output logic                              m_is_volume
);

    htfd_pkg::cfg_t              cfg;
    htfd_pkg::result_t           result;
    logic                        held_valid;
    logic [htfd_pkg::BYTE_W-1:0] held_byte;
    logic                        advance;

    // Advance the held item when the result register is free or draining.
    assign advance = held_valid && (!m_valid || m_ready);

    htfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    htfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    htfd_core #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .MAX_TAIL_BYTES   (MAX_TAIL_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .rx_byte (held_byte),
        .result  (result)
    );

    htfd_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (advance),
        .result          (result),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_category_byte (m_category_byte),
        .m_event_byte    (m_event_byte),
        .m_is_volume     (m_is_volume)
    );

endmodule

@@ rtl/core/htfd_cfg_regs.sv @@
// Configuration register file of the frame deframer.
module htfd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [htfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [htfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output htfd_pkg::cfg_t                    cfg
);

    htfd_pkg::cfg_t cfg_reg;
    htfd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (htfd_pkg::cfg_index_t'(cfg_index))
                htfd_pkg::CFG_HEADER_PATTERN:
                    cfg_next.header_pattern = cfg_wdata[htfd_pkg::PATTERN_W-1:0];
                htfd_pkg::CFG_HEADER_LEN:
                    cfg_next.header_len = cfg_wdata[htfd_pkg::LEN_W-1:0];
                htfd_pkg::CFG_TAIL_PATTERN:
                    cfg_next.tail_pattern = cfg_wdata[htfd_pkg::PATTERN_W-1:0];
                htfd_pkg::CFG_TAIL_LEN:
                    cfg_next.tail_len = cfg_wdata[htfd_pkg::LEN_W-1:0];
                htfd_pkg::CFG_VOLUME_CATEGORY:
                    cfg_next.volume_category = cfg_wdata[htfd_pkg::BYTE_W-1:0];
                htfd_pkg::CFG_VOLUME_ONLY:
                    cfg_next.volume_only = cfg_wdata[0];
                htfd_pkg::CFG_ACCEPT_ANY_TAIL:
                    cfg_next.accept_any_tail = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/htfd_in_stage.sv @@
// Input register of the frame deframer.
module htfd_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [htfd_pkg::BYTE_W-1:0]    s_rx_byte,
    input  logic                           advance,
    output logic                           held_valid,
    output logic [htfd_pkg::BYTE_W-1:0]    held_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [htfd_pkg::BYTE_W-1:0] byte_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

@@ rtl/core/htfd_core.sv @@
// Frame state and per-byte header, phase and tail update.
module htfd_core #(
    parameter int MAX_HEADER_BYTES = htfd_pkg::DEF_MAX_HEADER_BYTES,
    parameter int MAX_TAIL_BYTES   = htfd_pkg::DEF_MAX_TAIL_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  htfd_pkg::cfg_t                 cfg,
    input  logic                           step_en,
    input  logic [htfd_pkg::BYTE_W-1:0]    rx_byte,
    output htfd_pkg::result_t              result
);

    localparam int HCW = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;
    localparam int TCW = (MAX_TAIL_BYTES > 1) ? $clog2(MAX_TAIL_BYTES) : 1;
    localparam int CW  = htfd_pkg::CNT_W;
    localparam logic [CW-1:0] HMAX = CW'(MAX_HEADER_BYTES);
    localparam logic [CW-1:0] TMAX = CW'(MAX_TAIL_BYTES);

    logic [HCW-1:0]              hm_reg, hm_next;
    logic [TCW-1:0]              tm_reg, tm_next;
    htfd_pkg::phase_t            phase_reg, phase_next;
    logic [htfd_pkg::BYTE_W-1:0] hc_reg, hc_next;
    logic [htfd_pkg::BYTE_W-1:0] he_reg, he_next;

    logic [CW-1:0]    hlen, tlen;
    logic [CW-1:0]    hm_ext, tm_ext, hm_inc, tm_inc;
    htfd_pkg::phase_t dfl_phase, cur_phase, restart_phase;
    logic             hdr_hit, tail_hit, done;

    assign hlen   = htfd_pkg::used_len(cfg.header_len, HMAX);
    assign tlen   = htfd_pkg::used_len(cfg.tail_len, TMAX);
    assign hm_ext = {{(CW-HCW){1'b0}}, hm_reg};
    assign tm_ext = {{(CW-TCW){1'b0}}, tm_reg};
    assign hm_inc = hm_ext + CW'(1);
    assign tm_inc = tm_ext + CW'(1);

    assign restart_phase = cfg.volume_only ? htfd_pkg::PH_EVENT : htfd_pkg::PH_CATEGORY;
    assign dfl_phase     = (hlen != '0) ? htfd_pkg::PH_WAIT : restart_phase;
    assign cur_phase     = (phase_reg == htfd_pkg::PH_WAIT) ? dfl_phase : phase_reg;

    assign hdr_hit = (hlen != '0) && (hm_ext < hlen) &&
                     (rx_byte == htfd_pkg::pattern_byte(cfg.header_pattern, hm_ext));
    assign tail_hit = cfg.accept_any_tail ||
                      ((tm_ext < tlen) &&
                       (rx_byte == htfd_pkg::pattern_byte(cfg.tail_pattern, tm_ext)));

    always_comb begin
        hm_next    = hm_reg;
        tm_next    = tm_reg;
        phase_next = cur_phase;
        hc_next    = hc_reg;
        he_next    = he_reg;
        done       = 1'b0;
        if (hdr_hit && (hm_inc >= hlen)) begin
            // Full header: consume the byte and open a new frame.
            hm_next    = '0;
            tm_next    = '0;
            phase_next = restart_phase;
        end else begin
            hm_next = hdr_hit ? hm_inc[HCW-1:0] : '0;
            case (cur_phase)
                htfd_pkg::PH_CATEGORY: begin
                    hc_next    = rx_byte;
                    phase_next = htfd_pkg::PH_EVENT;
                end
                htfd_pkg::PH_EVENT: begin
                    he_next = rx_byte;
                    if (cfg.volume_only) begin
                        hc_next = rx_byte;
                    end
                    done       = (tlen == '0);
                    phase_next = htfd_pkg::PH_TAIL;
                end
                htfd_pkg::PH_TAIL: begin
                    if (tail_hit) begin
                        if (tm_inc >= tlen) begin
                            tm_next = '0;
                            done    = 1'b1;
                        end else begin
                            tm_next = tm_inc[TCW-1:0];
                        end
                    end else begin
                        // Drop the frame on a tail mismatch.
                        tm_next    = '0;
                        phase_next = dfl_phase;
                    end
                end
                default: ;
            endcase
            if (done) begin
                phase_next = dfl_phase;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hm_reg    <= '0;
            tm_reg    <= '0;
            phase_reg <= htfd_pkg::PH_WAIT;
            hc_reg    <= '0;
            he_reg    <= '0;
        end else if (step_en) begin
            hm_reg    <= hm_next;
            tm_reg    <= tm_next;
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            he_reg    <= he_next;
        end
    end

    always_comb begin
        result.valid         = done;
        result.category_byte = hc_next;
        result.event_byte    = he_next;
        result.is_volume     = cfg.volume_only || (hc_next == cfg.volume_category);
    end

endmodule

@@ rtl/core/htfd_out_stage.sv @@
// Result register of the frame deframer.
module htfd_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  htfd_pkg::result_t              result,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [htfd_pkg::BYTE_W-1:0]    m_category_byte,
    output logic [htfd_pkg::BYTE_W-1:0]    m_event_byte,
    output logic                           m_is_volume
);

    logic                        valid_reg, valid_next;
    logic [htfd_pkg::BYTE_W-1:0] category_reg;
    logic [htfd_pkg::BYTE_W-1:0] event_reg;
    logic                        is_volume_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            category_reg  <= result.category_byte;
            event_reg     <= result.event_byte;
            is_volume_reg <= result.is_volume;
        end
    end

    assign m_valid         = valid_reg;
    assign m_category_byte = category_reg;
    assign m_event_byte    = event_reg;
    assign m_is_volume     = is_volume_reg;

endmodule

@@ test/header_tail_frame_deframer_unit_tb.sv @@
// Self-checking testbench for the header/tail frame deframer: random framed byte streams.
module header_tail_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HDR      = htfd_pkg::DEF_MAX_HEADER_BYTES;
    localparam int MAX_TAIL     = htfd_pkg::DEF_MAX_TAIL_BYTES;
    localparam int PHASE_ITEMS  = 85;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    // header A5 5A, tail 0D, volume category 10
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h0D,
        8'hA5, 8'hA5, 8'h5A,
        8'hA5, 8'h5A, 8'h12, 8'h34, 8'h0E,
        8'hA5, 8'h5A, 8'h21, 8'hA5, 8'h5A, 8'h10, 8'h00, 8'h0D,
        8'hA5, 8'h5A, 8'h44, 8'h55
    };

    typedef struct packed {
        logic [htfd_pkg::BYTE_W-1:0] category_byte;
        logic [htfd_pkg::BYTE_W-1:0] event_byte;
        logic                        is_volume;
    } frame_rec_t;

    typedef enum {FR_GOOD, FR_CUT, FR_FLIP, FR_NOISE} frame_kind_t;

    logic                            aclk;
    logic                            aresetn         = 1'b0;
    logic                            cfg_wr_en       = 1'b0;
    logic [htfd_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [htfd_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic [htfd_pkg::BYTE_W-1:0]     s_rx_byte       = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic [htfd_pkg::BYTE_W-1:0]     m_category_byte;
    logic [htfd_pkg::BYTE_W-1:0]     m_event_byte;
    logic                            m_is_volume;

    // deframer mirror
    htfd_pkg::cfg_t   shadow_cfg = '0;
    htfd_pkg::phase_t phase      = htfd_pkg::PH_WAIT;
    int               hdr_cnt    = 0;
    int               tail_cnt   = 0;
    logic [7:0]       held_cat   = '0;
    logic [7:0]       held_evt   = '0;

    logic [7:0]  byte_q[$];
    frame_rec_t  frame_q[$];
    frame_rec_t  want;
    int          mismatches     = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int          hold_left      = 0;

    header_tail_frame_deframer_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_category_byte (m_category_byte),
        .m_event_byte    (m_event_byte),
        .m_is_volume     (m_is_volume)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("header_tail_frame_deframer_unit_tb: FAIL");
        $finish;
    end

    function automatic logic [7:0] pick_byte(input logic [31:0] pat, input int idx);
        return (idx < 4) ? 8'(pat >> (8 * idx)) : 8'h00;
    endfunction

    function automatic int clamp_len(input logic [2:0] len, input int max_len);
        return (int'(len) > max_len) ? max_len : int'(len);
    endfunction

    function automatic htfd_pkg::phase_t idle_phase();
        if (clamp_len(shadow_cfg.header_len, MAX_HDR) != 0)
            return htfd_pkg::PH_WAIT;
        return shadow_cfg.volume_only ? htfd_pkg::PH_EVENT : htfd_pkg::PH_CATEGORY;
    endfunction

    // Advance the mirror by one received byte; queue a frame when one completes.
    function automatic void deframe_byte(input logic [7:0] b);
        int               hlen;
        int               tlen;
        htfd_pkg::phase_t dfl;
        logic             done;
        frame_rec_t       rec;
        hlen = clamp_len(shadow_cfg.header_len, MAX_HDR);
        tlen = clamp_len(shadow_cfg.tail_len, MAX_TAIL);
        dfl  = idle_phase();
        done = 1'b0;
        if (phase == htfd_pkg::PH_WAIT)
            phase = dfl;
        if (hlen != 0 && hdr_cnt < hlen &&
            b == pick_byte(shadow_cfg.header_pattern, hdr_cnt)) begin
            hdr_cnt++;
            if (hdr_cnt >= hlen) begin
                hdr_cnt  = 0;
                tail_cnt = 0;
                phase    = shadow_cfg.volume_only ? htfd_pkg::PH_EVENT
                                                  : htfd_pkg::PH_CATEGORY;
                return;
            end
        end else begin
            hdr_cnt = 0;
        end
        case (phase)
            htfd_pkg::PH_CATEGORY: begin
                held_cat = b;
                phase    = htfd_pkg::PH_EVENT;
            end
            htfd_pkg::PH_EVENT: begin
                held_evt = b;
                if (shadow_cfg.volume_only)
                    held_cat = b;
                if (tlen == 0)
                    done = 1'b1;
                phase = htfd_pkg::PH_TAIL;
            end
            htfd_pkg::PH_TAIL: begin
                if (shadow_cfg.accept_any_tail ||
                    (tail_cnt < tlen && b == pick_byte(shadow_cfg.tail_pattern, tail_cnt))) begin
                    tail_cnt++;
                    if (tail_cnt >= tlen) begin
                        tail_cnt = 0;
                        done     = 1'b1;
                    end
                end else begin
                    // drop the frame
                    phase    = dfl;
                    tail_cnt = 0;
                    return;
                end
            end
            default: return;
        endcase
        if (done) begin
            phase             = dfl;
            rec.category_byte = held_cat;
            rec.event_byte    = held_evt;
            rec.is_volume     = shadow_cfg.volume_only || held_cat == shadow_cfg.volume_category;
            frame_q.push_back(rec);
        end
    endfunction

    // Sender: predict on each accepted item, then offer the next one or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, got cat %02h evt %02h vol %0b",
                         $realtime, m_category_byte, m_event_byte, m_is_volume);
                mismatches++;
            end else begin
                want = frame_q.pop_front();
                if (m_category_byte !== want.category_byte) begin
                    $display("%0t: category_byte expected %02h got %02h",
                             $realtime, want.category_byte, m_category_byte);
                    mismatches++;
                end
                if (m_event_byte !== want.event_byte) begin
                    $display("%0t: event_byte expected %02h got %02h",
                             $realtime, want.event_byte, m_event_byte);
                    mismatches++;
                end
                if (m_is_volume !== want.is_volume) begin
                    $display("%0t: is_volume expected %0b got %0b",
                             $realtime, want.is_volume, m_is_volume);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input htfd_pkg::cfg_index_t idx,
                             input logic [htfd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            htfd_pkg::CFG_HEADER_PATTERN:
                shadow_cfg.header_pattern  = val;
            htfd_pkg::CFG_HEADER_LEN:
                shadow_cfg.header_len      = val[htfd_pkg::LEN_W-1:0];
            htfd_pkg::CFG_TAIL_PATTERN:
                shadow_cfg.tail_pattern    = val;
            htfd_pkg::CFG_TAIL_LEN:
                shadow_cfg.tail_len        = val[htfd_pkg::LEN_W-1:0];
            htfd_pkg::CFG_VOLUME_CATEGORY:
                shadow_cfg.volume_category = val[7:0];
            htfd_pkg::CFG_VOLUME_ONLY:
                shadow_cfg.volume_only     = val[0];
            htfd_pkg::CFG_ACCEPT_ANY_TAIL:
                shadow_cfg.accept_any_tail = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setting(input logic [31:0] hpat, input logic [2:0] hl,
                                input logic [31:0] tpat, input logic [2:0] tl,
                                input logic [7:0] vcat, input logic vo, input logic any);
        write_reg(htfd_pkg::CFG_HEADER_PATTERN, hpat);
        write_reg(htfd_pkg::CFG_HEADER_LEN, 32'(hl));
        write_reg(htfd_pkg::CFG_TAIL_PATTERN, tpat);
        write_reg(htfd_pkg::CFG_TAIL_LEN, 32'(tl));
        write_reg(htfd_pkg::CFG_VOLUME_CATEGORY, 32'(vcat));
        write_reg(htfd_pkg::CFG_VOLUME_ONLY, 32'(vo));
        write_reg(htfd_pkg::CFG_ACCEPT_ANY_TAIL, 32'(any));
    endtask

    // Wait until every item is in and every frame is out, then let the pipeline settle.
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_valid || frame_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_frame(input frame_kind_t kind, inout int count);
        logic [7:0] seq[$];
        int         hlen;
        int         tlen;
        int         k;
        int         keep;
        logic [7:0] cat;
        hlen = clamp_len(shadow_cfg.header_len, MAX_HDR);
        tlen = clamp_len(shadow_cfg.tail_len, MAX_TAIL);
        for (k = 0; k < hlen; k++)
            seq.push_back(pick_byte(shadow_cfg.header_pattern, k));
        cat = ($urandom_range(2) == 0) ? shadow_cfg.volume_category : 8'($urandom);
        if (!shadow_cfg.volume_only)
            seq.push_back(cat);
        seq.push_back(8'($urandom));
        for (k = 0; k < tlen; k++)
            seq.push_back(shadow_cfg.accept_any_tail ? 8'($urandom)
                                                     : pick_byte(shadow_cfg.tail_pattern, k));
        case (kind)
            FR_CUT: begin
                keep = $urandom_range(seq.size() - 1);
                while (seq.size() > keep)
                    void'(seq.pop_back());
            end
            FR_FLIP: begin
                k      = $urandom_range(seq.size() - 1);
                seq[k] = seq[k] ^ 8'($urandom_range(255, 1));
            end
            FR_NOISE: begin
                seq.delete();
                repeat ($urandom_range(4, 1)) seq.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (seq[i])
            byte_q.push_back(seq[i]);
        count += seq.size();
    endtask

    task automatic run_random_phase(input logic [2:0] hl, input logic [2:0] tl,
                                    input logic vo, input logic any, input logic [7:0] vcat,
                                    input int idle_src, input int stall_sink, input bit squeeze);
        int count;
        int pick;
        wait_drained();
        load_setting($urandom, hl, $urandom, tl, vcat, vo, any);
        src_idle_pct   = idle_src;
        sink_stall_pct = stall_sink;
        count = 0;
        while (count < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_frame(FR_GOOD, count);
            else if (pick < 80)
                add_frame(FR_CUT, count);
            else if (pick < 90)
                add_frame(FR_FLIP, count);
            else
                add_frame(FR_NOISE, count);
        end
        // leave the deframer mid-frame for the next setting
        add_frame(FR_CUT, count);
        if (squeeze) begin
            @(posedge aclk);
            hold_req <= 1'b1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_setting(32'h0000_5AA5, 3'd2, 32'h0000_000D, 3'd1, 8'h10, 1'b0, 1'b0);
        foreach (DIRECTED_BYTES[i])
            byte_q.push_back(DIRECTED_BYTES[i]);
        wait_drained();

        //               hl    tl    vo    any   vcat   idle stall squeeze
        run_random_phase(3'd0, 3'd0, 1'b0, 1'b1, 8'h00, 0,   0,    1'b0);
        run_random_phase(3'd2, 3'd2, 1'b0, 1'b0, 8'hFF, 76,  0,    1'b0);
        run_random_phase(3'd4, 3'd4, 1'b0, 1'b0, 8'($urandom), 0, 76, 1'b0);
        run_random_phase(3'd7, 3'd7, 1'b1, 1'b0, 8'h00, 9,   9,    1'b0);
        run_random_phase(3'd0, 3'd0, 1'b1, 1'b0, 8'hFF, 0,   0,    1'b1);
        run_random_phase(3'd1, 3'd3, 1'b0, 1'b1, 8'($urandom), 76, 0, 1'b0);
        run_random_phase(3'd3, 3'd1, 1'b1, 1'b1, 8'h00, 0,   76,   1'b0);
        run_random_phase(3'd0, 3'd3, 1'b0, 1'b0, 8'hFF, 9,   9,    1'b0);
        run_random_phase(3'd5, 3'd6, 1'b0, 1'b0, 8'($urandom), 0, 0, 1'b0);

        if (mismatches == 0) begin
            $display("header_tail_frame_deframer_unit_tb: PASS");
        end else begin
            $display("header_tail_frame_deframer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/htfd_pkg.sv
rtl/core/htfd_cfg_regs.sv
rtl/core/htfd_in_stage.sv
rtl/core/htfd_core.sv
rtl/core/htfd_out_stage.sv
rtl/core/header_tail_frame_deframer_unit.sv
test/header_tail_frame_deframer_unit_tb.sv
